### design/gist_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gist_pkg
// Shared types and codes for the gapped id slot table.
// ----------------------------------------------------------------------------
package gist_pkg;

  // request codes
  typedef enum logic [3:0] {
    OP_ADD        = 4'd0,
    OP_INS_HEAD   = 4'd1,
    OP_INS_TAIL   = 4'd2,
    OP_INS_BEFORE = 4'd3,
    OP_INS_AFTER  = 4'd4,
    OP_REMOVE     = 4'd5,
    OP_DELETE     = 4'd6,
    OP_LOCATE     = 4'd7,
    OP_READ       = 4'd8,
    OP_HEAD       = 4'd9,
    OP_TAIL       = 4'd10,
    OP_NEXT       = 4'd11,
    OP_PREV       = 4'd12,
    OP_FLUSH      = 4'd13
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // configuration register indexes
  localparam logic [1:0] CFG_SORTED  = 2'd0;
  localparam logic [1:0] CFG_COMPACT = 2'd1;
  localparam logic [1:0] CFG_INIT    = 2'd2;

  localparam int unsigned INIT_SLOTS_RST = 8;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] item_id;
    logic [5:0]  slot_index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  found_index;
    logic [31:0] found_id;
    logic [6:0]  entry_count;
  } rsp_t;

  typedef enum logic [2:0] {
    P_HOLD, P_ZERO, P_SIU, P_IDX, P_IDX1, P_INC, P_DEC, P_POS
  } ptr_sel_e;

  typedef enum logic [2:0] {
    Q_HOLD, Q_ZERO, Q_PTR, Q_PTR1, Q_IDX, Q_IDX1, Q_HALF
  } pos_sel_e;

  typedef enum logic [1:0] {
    F_HOLD, F_PTR, F_PTRM1, F_IDX
  } fidx_sel_e;

  typedef enum logic [1:0] {
    R_PTR, R_PTRM1, R_PTRP1, R_FIDX
  } raddr_sel_e;

  typedef enum logic [1:0] {
    W_PTR, W_POS, W_POSM1, W_SIU
  } waddr_sel_e;

  typedef enum logic {
    D_ID, D_RDATA
  } wdata_sel_e;

  typedef enum logic [2:0] {
    V_NONE, V_SET_W, V_SET_SIU, V_CLR_PTR, V_COPY, V_CLR_LAST
  } vop_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_FWD, S_FREE, S_BWD, S_IDS_CHK, S_IDS_CMP, S_RD, S_RD_DATA,
    S_INS, S_LIM, S_SH_RD, S_SH_WR, S_CLR, S_CL_CHK, S_CL_WR
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    ptr_sel_e   ptr_sel;
    pos_sel_e   pos_sel;
    fidx_sel_e  fidx_sel;
    raddr_sel_e raddr_sel;
    logic       wr_en;
    waddr_sel_e waddr_sel;
    wdata_sel_e wdata_sel;
    vop_e       vop;
    logic       grow;
    logic       shrink;
    logic       occ_inc;
    logic       occ_dec;
    logic       flush;
    logic       empty_set;
    logic       empty_clr;
    logic       fid_ld;
    logic       fin;
    status_e    fin_status;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [3:0] op;
    logic       bad_id;
    logic       sorted;
    logic       compact;
    logic       occ_zero;
    logic       ptr_end;
    logic       v_ptr;
    logic       ptr_zero;
    logic       v_ptrm1;
    logic       ptr_gt_pos;
    logic       pos_end;
    logic       v_pos;
    logic       pos_zero;
    logic       v_posm1;
    logic       full;
    logic       rd_eq;
    logic       rd_gt;
    logic       empty;
    logic       ptr1_lt;
    logic       idx_hit;
  } stat_t;

endpackage
`default_nettype wire

### design/gapped_id_slot_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gapped_id_slot_table
// Slot table of object ids with empty slots, sorted and compact modes.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Busy then stays
// high until the request completes. The result shows on result_o for exactly
// one cycle with done_o high: the first cycle in which busy is low again.
// The receiver cannot stall, so a result must be taken in that cycle.
// Flush and a refused request finish in the dispatch state. An unsorted
// add first scans for a free slot. Scans over the valid bits test one slot
// at a time. Anything that compares or moves stored ids takes a read step
// and then a compare or write step per slot, since the id store is a single
// RAM with one write and one registered read port. The worst case is a head
// insert into a run of taken slots: it walks to the first empty slot, or
// grows the table, and then shifts every entry right. There is no clearing
// pass after reset.
// Configuration writes are always ready and belong in idle periods; a new
// initial_slots value takes effect at the next flush.
// ----------------------------------------------------------------------------
module gapped_id_slot_table #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned ID_WIDTH = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  // request
  input  wire logic           start,
  output logic                busy,
  input  wire gist_pkg::cmd_t cmd_i,
  // result, one cycle transfer
  output logic                done_o,
  output gist_pkg::rsp_t      result_o,
  // configuration writes
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [6:0]     cfg_data_i
);

  gist_pkg::ctl_t  ctl;
  gist_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  gist_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  gist_dp #(
    .CAPACITY (CAPACITY),
    .ID_WIDTH (ID_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .result_o    (result_o),
    .done_o      (done_o)
  );

endmodule
`default_nettype wire

### design/gist_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gist_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gist_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### design/gist_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gist_dp
// Datapath: id RAM, valid bits, pointers, counters, config and result regs.
// ----------------------------------------------------------------------------
module gist_dp #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned ID_WIDTH = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire gist_pkg::cmd_t cmd_i,
  input  wire logic          cfg_valid_i,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [6:0]    cfg_data_i,
  input  wire gist_pkg::ctl_t ctl_i,
  output gist_pkg::stat_t    stat_o,
  output gist_pkg::rsp_t     result_o,
  output logic               done_o
);

  localparam int unsigned KW = (ID_WIDTH < 32) ? ID_WIDTH : 32;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW + 1 > 7) ? CW + 1 : 7;
  localparam int unsigned FW = (AW > 6) ? AW : 6;
  localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);
  localparam logic [XW-1:0] RST_SLOTS_X =
      (gist_pkg::INIT_SLOTS_RST > CAPACITY) ? XW'(CAPACITY) : XW'(gist_pkg::INIT_SLOTS_RST);

  logic [3:0]          op_q;
  logic [KW-1:0]       id_q;
  logic [5:0]          idx_q;
  logic [CW-1:0]       ptr_q, pos_q, siu_q, occ_q;
  logic [FW-1:0]       fidx_q;
  logic [KW-1:0]       fid_q;
  logic                empty_q;
  logic [CAPACITY-1:0] valid_q;
  logic [1:0]          status_q;
  logic                done_q;
  logic                sorted_q, compact_q;
  logic [6:0]          init_q;

  logic [KW-1:0] rdata;
  logic [KW-1:0] wdata;
  logic [AW-1:0] raddr, waddr;

  logic [CW-1:0] ptrm1, posm1, idx_cl, idx1_cl, start_slots, grow_n;
  logic [XW-1:0] siu_x, idx_x, idx1_x, init_x, st_x, g_x;

  assign siu_x  = XW'(siu_q);
  assign idx_x  = XW'(idx_q);
  assign idx1_x = idx_x + XW'(1);
  assign init_x = XW'(init_q);
  assign ptrm1  = ptr_q - CW'(1);
  assign posm1  = pos_q - CW'(1);
  assign idx_cl  = (idx_x  < siu_x) ? CW'(idx_x)  : siu_q;
  assign idx1_cl = (idx1_x < siu_x) ? CW'(idx1_x) : siu_q;

  // slots after flush: zero reads as one, oversize clamps to capacity
  always_comb begin
    st_x = init_x;
    if (init_x == '0) st_x = XW'(1);
    if (init_x > CAP_X) st_x = CAP_X;
  end
  assign start_slots = CW'(st_x);

  // growth: double or add one, at least one slot, saturate at capacity
  always_comb begin
    g_x = compact_q ? (siu_x + XW'(1)) : (siu_x << 1);
    if (g_x < siu_x + XW'(1)) g_x = siu_x + XW'(1);
    if (g_x > CAP_X) g_x = CAP_X;
  end
  assign grow_n = CW'(g_x);

  always_comb begin
    case (ctl_i.raddr_sel)
      gist_pkg::R_PTR:   raddr = AW'(ptr_q);
      gist_pkg::R_PTRM1: raddr = AW'(ptrm1);
      gist_pkg::R_PTRP1: raddr = AW'(ptr_q + CW'(1));
      gist_pkg::R_FIDX:  raddr = AW'(fidx_q);
      default:           raddr = AW'(ptr_q);
    endcase
    case (ctl_i.waddr_sel)
      gist_pkg::W_PTR:   waddr = AW'(ptr_q);
      gist_pkg::W_POS:   waddr = AW'(pos_q);
      gist_pkg::W_POSM1: waddr = AW'(posm1);
      gist_pkg::W_SIU:   waddr = AW'(siu_q);
      default:           waddr = AW'(ptr_q);
    endcase
  end
  assign wdata = (ctl_i.wdata_sel == gist_pkg::D_RDATA) ? rdata : id_q;

  gist_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // status toward the controller
  always_comb begin
    stat_o.op         = op_q;
    stat_o.bad_id     = (ID_WIDTH <= 32) && (&id_q);
    stat_o.sorted     = sorted_q;
    stat_o.compact    = compact_q;
    stat_o.occ_zero   = (occ_q == '0);
    stat_o.ptr_end    = (ptr_q >= siu_q);
    stat_o.v_ptr      = valid_q[AW'(ptr_q)];
    stat_o.ptr_zero   = (ptr_q == '0);
    stat_o.v_ptrm1    = valid_q[AW'(ptrm1)];
    stat_o.ptr_gt_pos = (ptr_q > pos_q);
    stat_o.pos_end    = (pos_q >= siu_q);
    stat_o.v_pos      = valid_q[AW'(pos_q)];
    stat_o.pos_zero   = (pos_q == '0);
    stat_o.v_posm1    = valid_q[AW'(posm1)];
    stat_o.full       = (siu_x >= CAP_X);
    stat_o.rd_eq      = (rdata == id_q);
    stat_o.rd_gt      = (rdata > id_q);
    stat_o.empty      = empty_q;
    stat_o.ptr1_lt    = (XW'(ptr_q) + XW'(1) < siu_x);
    stat_o.idx_hit    = (idx_x < siu_x) && valid_q[AW'(idx_q)];
  end

  // request latch and pointers (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q  <= cmd_i.op;
      id_q  <= cmd_i.item_id[KW-1:0];
      idx_q <= cmd_i.slot_index;
    end
    case (ctl_i.ptr_sel)
      gist_pkg::P_ZERO: ptr_q <= '0;
      gist_pkg::P_SIU:  ptr_q <= siu_q;
      gist_pkg::P_IDX:  ptr_q <= idx_cl;
      gist_pkg::P_IDX1: ptr_q <= idx1_cl;
      gist_pkg::P_INC:  ptr_q <= ptr_q + CW'(1);
      gist_pkg::P_DEC:  ptr_q <= ptrm1;
      gist_pkg::P_POS:  ptr_q <= pos_q;
      default:          ptr_q <= ptr_q;
    endcase
    case (ctl_i.pos_sel)
      gist_pkg::Q_ZERO: pos_q <= '0;
      gist_pkg::Q_PTR:  pos_q <= ptr_q;
      gist_pkg::Q_PTR1: pos_q <= ptr_q + CW'(1);
      gist_pkg::Q_IDX:  pos_q <= idx_cl;
      gist_pkg::Q_IDX1: pos_q <= idx1_cl;
      gist_pkg::Q_HALF: pos_q <= siu_q >> 1;
      default:          pos_q <= pos_q;
    endcase
    if (ctl_i.load) begin
      fidx_q <= '0;
    end else begin
      case (ctl_i.fidx_sel)
        gist_pkg::F_PTR:   fidx_q <= FW'(ptr_q);
        gist_pkg::F_PTRM1: fidx_q <= FW'(ptrm1);
        gist_pkg::F_IDX:   fidx_q <= FW'(idx_q);
        default:           fidx_q <= fidx_q;
      endcase
    end
    if (ctl_i.load) begin
      fid_q <= '0;
    end else if (ctl_i.fid_ld) begin
      fid_q <= rdata;
    end
    if (ctl_i.empty_set) begin
      empty_q <= 1'b1;
    end else if (ctl_i.empty_clr) begin
      empty_q <= 1'b0;
    end
  end

  // table state, config and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      siu_q     <= CW'(RST_SLOTS_X);
      occ_q     <= '0;
      status_q  <= '0;
      done_q    <= 1'b0;
      sorted_q  <= 1'b0;
      compact_q <= 1'b0;
      init_q    <= 7'(gist_pkg::INIT_SLOTS_RST);
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          gist_pkg::CFG_SORTED:  sorted_q  <= cfg_data_i[0];
          gist_pkg::CFG_COMPACT: compact_q <= cfg_data_i[0];
          gist_pkg::CFG_INIT:    init_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (ctl_i.flush) begin
        valid_q <= '0;
        siu_q   <= start_slots;
        occ_q   <= '0;
      end else begin
        case (ctl_i.vop)
          gist_pkg::V_SET_W:    valid_q[waddr] <= 1'b1;
          gist_pkg::V_SET_SIU:  valid_q[AW'(siu_q)] <= 1'b1;
          gist_pkg::V_CLR_PTR:  valid_q[AW'(ptr_q)] <= 1'b0;
          gist_pkg::V_COPY:     valid_q[AW'(ptr_q)] <= valid_q[AW'(ptr_q + CW'(1))];
          gist_pkg::V_CLR_LAST: valid_q[AW'(siu_q - CW'(1))] <= 1'b0;
          default: ;
        endcase
        if (ctl_i.grow) begin
          siu_q <= grow_n;
        end else if (ctl_i.shrink) begin
          siu_q <= siu_q - CW'(1);
        end
        if (ctl_i.occ_inc) begin
          occ_q <= occ_q + CW'(1);
        end else if (ctl_i.occ_dec) begin
          occ_q <= occ_q - CW'(1);
        end
      end
      done_q <= ctl_i.fin;
      if (ctl_i.fin) begin
        status_q <= ctl_i.fin_status;
      end
    end
  end

  always_comb begin
    result_o.status      = status_q;
    result_o.found_index = 6'(fidx_q);
    result_o.found_id    = 32'(fid_q);
    result_o.entry_count = 7'(occ_q);
  end
  assign done_o = done_q;

endmodule
`default_nettype wire

### design/gist_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gist_ctrl
// Request sequencer: scans, shifts and result timing.
// ----------------------------------------------------------------------------
module gist_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire gist_pkg::stat_t stat_i,
  output gist_pkg::ctl_t       ctl_o
);

  gist_pkg::state_e state_q, state_d;
  logic is_tail_ins, id_op;

  assign is_tail_ins = (stat_i.op == gist_pkg::OP_INS_TAIL);
  // requests that carry an id; they refuse the all-ones id when ID_WIDTH <= 32
  assign id_op = (stat_i.op == gist_pkg::OP_ADD) || (stat_i.op == gist_pkg::OP_INS_HEAD) ||
                 (stat_i.op == gist_pkg::OP_INS_TAIL) ||
                 (stat_i.op == gist_pkg::OP_INS_BEFORE) ||
                 (stat_i.op == gist_pkg::OP_INS_AFTER) ||
                 (stat_i.op == gist_pkg::OP_REMOVE) || (stat_i.op == gist_pkg::OP_LOCATE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gist_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != gist_pkg::S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gist_pkg::S_IDLE: begin
        if (start) state_d = gist_pkg::S_DISP;
      end
      gist_pkg::S_DISP: begin
        state_d = gist_pkg::S_IDLE;
        if (!(id_op && stat_i.bad_id)) begin
          case (stat_i.op)
            gist_pkg::OP_ADD:
              state_d = stat_i.sorted ? gist_pkg::S_IDS_CHK : gist_pkg::S_FREE;
            gist_pkg::OP_INS_HEAD, gist_pkg::OP_INS_BEFORE, gist_pkg::OP_INS_AFTER: begin
              if (!stat_i.sorted) state_d = gist_pkg::S_INS;
            end
            gist_pkg::OP_INS_TAIL: begin
              if (!stat_i.sorted) state_d = gist_pkg::S_BWD;
            end
            gist_pkg::OP_REMOVE: begin
              if (!stat_i.occ_zero) state_d = gist_pkg::S_IDS_CHK;
            end
            gist_pkg::OP_DELETE: begin
              if (stat_i.idx_hit) state_d = gist_pkg::S_CLR;
            end
            gist_pkg::OP_LOCATE: state_d = gist_pkg::S_IDS_CHK;
            gist_pkg::OP_READ: begin
              if (stat_i.idx_hit) state_d = gist_pkg::S_RD;
            end
            gist_pkg::OP_HEAD, gist_pkg::OP_NEXT: state_d = gist_pkg::S_FWD;
            gist_pkg::OP_TAIL, gist_pkg::OP_PREV: state_d = gist_pkg::S_BWD;
            default: state_d = gist_pkg::S_IDLE;
          endcase
        end
      end
      gist_pkg::S_FWD: begin
        if (stat_i.ptr_end) state_d = gist_pkg::S_IDLE;
        else if (stat_i.v_ptr) state_d = gist_pkg::S_RD;
      end
      gist_pkg::S_FREE: begin
        if (stat_i.ptr_end || !stat_i.v_ptr) state_d = gist_pkg::S_INS;
      end
      gist_pkg::S_BWD: begin
        if (stat_i.ptr_zero || stat_i.v_ptrm1) begin
          if (is_tail_ins) state_d = gist_pkg::S_INS;
          else if (stat_i.ptr_zero) state_d = gist_pkg::S_IDLE;
          else state_d = gist_pkg::S_RD;
        end
      end
      gist_pkg::S_IDS_CHK: begin
        if (stat_i.ptr_end) begin
          state_d = (stat_i.op == gist_pkg::OP_ADD) ? gist_pkg::S_INS : gist_pkg::S_IDLE;
        end else if (stat_i.v_ptr) begin
          state_d = gist_pkg::S_IDS_CMP;
        end
      end
      gist_pkg::S_IDS_CMP: begin
        state_d = gist_pkg::S_IDS_CHK;
        case (stat_i.op)
          gist_pkg::OP_ADD: begin
            if (stat_i.rd_eq) state_d = gist_pkg::S_IDLE;
            else if (stat_i.rd_gt) state_d = gist_pkg::S_INS;
          end
          gist_pkg::OP_REMOVE: begin
            if (stat_i.sorted && stat_i.rd_gt) state_d = gist_pkg::S_IDLE;
            else if (stat_i.rd_eq) state_d = gist_pkg::S_CLR;
          end
          default: begin
            if (stat_i.rd_eq) state_d = gist_pkg::S_IDLE;
          end
        endcase
      end
      gist_pkg::S_RD:      state_d = gist_pkg::S_RD_DATA;
      gist_pkg::S_RD_DATA: state_d = gist_pkg::S_IDLE;
      gist_pkg::S_INS: begin
        if (stat_i.pos_end || !stat_i.v_pos ||
            (!stat_i.pos_zero && !stat_i.compact && !stat_i.v_posm1)) begin
          state_d = gist_pkg::S_IDLE;
        end else begin
          state_d = gist_pkg::S_LIM;
        end
      end
      gist_pkg::S_LIM: begin
        if (stat_i.ptr_end) begin
          state_d = stat_i.full ? gist_pkg::S_IDLE : gist_pkg::S_SH_RD;
        end else if (!stat_i.v_ptr) begin
          state_d = gist_pkg::S_SH_RD;
        end
      end
      gist_pkg::S_SH_RD: begin
        state_d = stat_i.ptr_gt_pos ? gist_pkg::S_SH_WR : gist_pkg::S_IDLE;
      end
      gist_pkg::S_SH_WR: state_d = gist_pkg::S_SH_RD;
      gist_pkg::S_CLR: begin
        state_d = stat_i.compact ? gist_pkg::S_CL_CHK : gist_pkg::S_IDLE;
      end
      gist_pkg::S_CL_CHK: begin
        state_d = stat_i.ptr1_lt ? gist_pkg::S_CL_WR : gist_pkg::S_IDLE;
      end
      gist_pkg::S_CL_WR: state_d = gist_pkg::S_CL_CHK;
      default: state_d = gist_pkg::S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    ctl_o = '0;
    ctl_o.fin_status = gist_pkg::ST_MISS;
    case (state_q)
      gist_pkg::S_IDLE: begin
        ctl_o.load = start;
      end
      gist_pkg::S_DISP: begin
        if (id_op && stat_i.bad_id) begin
          ctl_o.fin = 1'b1;
        end else begin
          case (stat_i.op)
            gist_pkg::OP_ADD: begin
              ctl_o.ptr_sel   = gist_pkg::P_ZERO;
              ctl_o.pos_sel   = gist_pkg::Q_ZERO;
              ctl_o.empty_set = 1'b1;
            end
            gist_pkg::OP_INS_HEAD: begin
              ctl_o.pos_sel = gist_pkg::Q_ZERO;
              ctl_o.fin     = stat_i.sorted;
            end
            gist_pkg::OP_INS_BEFORE: begin
              ctl_o.pos_sel = gist_pkg::Q_IDX;
              ctl_o.fin     = stat_i.sorted;
            end
            gist_pkg::OP_INS_AFTER: begin
              ctl_o.pos_sel = gist_pkg::Q_IDX1;
              ctl_o.fin     = stat_i.sorted;
            end
            gist_pkg::OP_INS_TAIL: begin
              ctl_o.ptr_sel = gist_pkg::P_SIU;
              ctl_o.fin     = stat_i.sorted;
            end
            gist_pkg::OP_REMOVE: begin
              ctl_o.ptr_sel = gist_pkg::P_ZERO;
              ctl_o.fin     = stat_i.occ_zero;
            end
            gist_pkg::OP_DELETE: begin
              ctl_o.ptr_sel = gist_pkg::P_IDX;
              ctl_o.fin     = !stat_i.idx_hit;
            end
            gist_pkg::OP_LOCATE, gist_pkg::OP_HEAD: begin
              ctl_o.ptr_sel = gist_pkg::P_ZERO;
            end
            gist_pkg::OP_READ: begin
              ctl_o.fidx_sel = gist_pkg::F_IDX;
              ctl_o.fin      = !stat_i.idx_hit;
            end
            gist_pkg::OP_TAIL: ctl_o.ptr_sel = gist_pkg::P_SIU;
            gist_pkg::OP_NEXT: ctl_o.ptr_sel = gist_pkg::P_IDX1;
            gist_pkg::OP_PREV: ctl_o.ptr_sel = gist_pkg::P_IDX;
            gist_pkg::OP_FLUSH: begin
              ctl_o.flush      = 1'b1;
              ctl_o.fin        = 1'b1;
              ctl_o.fin_status = gist_pkg::ST_OK;
            end
            default: ctl_o.fin = 1'b1;
          endcase
        end
      end
      gist_pkg::S_FWD: begin
        if (stat_i.ptr_end) ctl_o.fin = 1'b1;
        else if (stat_i.v_ptr) ctl_o.fidx_sel = gist_pkg::F_PTR;
        else ctl_o.ptr_sel = gist_pkg::P_INC;
      end
      gist_pkg::S_FREE: begin
        if (stat_i.ptr_end || !stat_i.v_ptr) ctl_o.pos_sel = gist_pkg::Q_PTR;
        else ctl_o.ptr_sel = gist_pkg::P_INC;
      end
      gist_pkg::S_BWD: begin
        if (stat_i.ptr_zero) begin
          if (is_tail_ins) ctl_o.pos_sel = gist_pkg::Q_ZERO;
          else ctl_o.fin = 1'b1;
        end else if (stat_i.v_ptrm1) begin
          if (is_tail_ins) ctl_o.pos_sel = gist_pkg::Q_PTR;
          else ctl_o.fidx_sel = gist_pkg::F_PTRM1;
        end else begin
          ctl_o.ptr_sel = gist_pkg::P_DEC;
        end
      end
      gist_pkg::S_IDS_CHK: begin
        ctl_o.raddr_sel = gist_pkg::R_PTR;
        if (stat_i.ptr_end) begin
          if (stat_i.op == gist_pkg::OP_ADD) begin
            if (stat_i.empty) ctl_o.pos_sel = gist_pkg::Q_HALF;
          end else begin
            ctl_o.fin = 1'b1;
          end
        end else if (!stat_i.v_ptr) begin
          ctl_o.ptr_sel = gist_pkg::P_INC;
        end
      end
      gist_pkg::S_IDS_CMP: begin
        case (stat_i.op)
          gist_pkg::OP_ADD: begin
            ctl_o.empty_clr = 1'b1;
            if (stat_i.rd_eq) begin
              ctl_o.fin = 1'b1;
            end else if (!stat_i.rd_gt) begin
              ctl_o.pos_sel = gist_pkg::Q_PTR1;
              ctl_o.ptr_sel = gist_pkg::P_INC;
            end
          end
          gist_pkg::OP_REMOVE: begin
            if (stat_i.sorted && stat_i.rd_gt) ctl_o.fin = 1'b1;
            else if (!stat_i.rd_eq) ctl_o.ptr_sel = gist_pkg::P_INC;
          end
          default: begin
            if (stat_i.rd_eq) begin
              ctl_o.fidx_sel   = gist_pkg::F_PTR;
              ctl_o.fid_ld     = 1'b1;
              ctl_o.fin        = 1'b1;
              ctl_o.fin_status = gist_pkg::ST_OK;
            end else begin
              ctl_o.ptr_sel = gist_pkg::P_INC;
            end
          end
        endcase
      end
      gist_pkg::S_RD: begin
        ctl_o.raddr_sel = gist_pkg::R_FIDX;
      end
      gist_pkg::S_RD_DATA: begin
        ctl_o.fid_ld     = 1'b1;
        ctl_o.fin        = 1'b1;
        ctl_o.fin_status = gist_pkg::ST_OK;
      end
      gist_pkg::S_INS: begin
        ctl_o.wdata_sel = gist_pkg::D_ID;
        if (stat_i.pos_end) begin
          ctl_o.fin = 1'b1;
          if (stat_i.full) begin
            ctl_o.fin_status = gist_pkg::ST_FULL;
          end else begin
            ctl_o.waddr_sel  = gist_pkg::W_SIU;
            ctl_o.wr_en      = 1'b1;
            ctl_o.vop        = gist_pkg::V_SET_W;
            ctl_o.grow       = 1'b1;
            ctl_o.occ_inc    = 1'b1;
            ctl_o.fin_status = gist_pkg::ST_OK;
          end
        end else if (!stat_i.v_pos) begin
          ctl_o.waddr_sel  = gist_pkg::W_POS;
          ctl_o.wr_en      = 1'b1;
          ctl_o.vop        = gist_pkg::V_SET_W;
          ctl_o.occ_inc    = 1'b1;
          ctl_o.fin        = 1'b1;
          ctl_o.fin_status = gist_pkg::ST_OK;
        end else if (!stat_i.pos_zero && !stat_i.compact && !stat_i.v_posm1) begin
          ctl_o.waddr_sel  = gist_pkg::W_POSM1;
          ctl_o.wr_en      = 1'b1;
          ctl_o.vop        = gist_pkg::V_SET_W;
          ctl_o.occ_inc    = 1'b1;
          ctl_o.fin        = 1'b1;
          ctl_o.fin_status = gist_pkg::ST_OK;
        end else begin
          ctl_o.ptr_sel = gist_pkg::P_POS;
        end
      end
      gist_pkg::S_LIM: begin
        if (stat_i.ptr_end) begin
          if (stat_i.full) begin
            ctl_o.fin        = 1'b1;
            ctl_o.fin_status = gist_pkg::ST_FULL;
          end else begin
            // new last slot is filled by the first shift step
            ctl_o.vop  = gist_pkg::V_SET_SIU;
            ctl_o.grow = 1'b1;
          end
        end else if (stat_i.v_ptr) begin
          ctl_o.ptr_sel = gist_pkg::P_INC;
        end
      end
      gist_pkg::S_SH_RD: begin
        ctl_o.raddr_sel = gist_pkg::R_PTRM1;
        if (!stat_i.ptr_gt_pos) begin
          ctl_o.waddr_sel  = gist_pkg::W_POS;
          ctl_o.wdata_sel  = gist_pkg::D_ID;
          ctl_o.wr_en      = 1'b1;
          ctl_o.vop        = gist_pkg::V_SET_W;
          ctl_o.occ_inc    = 1'b1;
          ctl_o.fin        = 1'b1;
          ctl_o.fin_status = gist_pkg::ST_OK;
        end
      end
      gist_pkg::S_SH_WR: begin
        ctl_o.waddr_sel = gist_pkg::W_PTR;
        ctl_o.wdata_sel = gist_pkg::D_RDATA;
        ctl_o.wr_en     = 1'b1;
        ctl_o.vop       = gist_pkg::V_SET_W;
        ctl_o.ptr_sel   = gist_pkg::P_DEC;
      end
      gist_pkg::S_CLR: begin
        ctl_o.vop     = gist_pkg::V_CLR_PTR;
        ctl_o.occ_dec = 1'b1;
        if (!stat_i.compact) begin
          ctl_o.fin        = 1'b1;
          ctl_o.fin_status = gist_pkg::ST_OK;
        end
      end
      gist_pkg::S_CL_CHK: begin
        ctl_o.raddr_sel = gist_pkg::R_PTRP1;
        if (!stat_i.ptr1_lt) begin
          ctl_o.vop        = gist_pkg::V_CLR_LAST;
          ctl_o.shrink     = 1'b1;
          ctl_o.fin        = 1'b1;
          ctl_o.fin_status = gist_pkg::ST_OK;
        end
      end
      gist_pkg::S_CL_WR: begin
        ctl_o.waddr_sel = gist_pkg::W_PTR;
        ctl_o.wdata_sel = gist_pkg::D_RDATA;
        ctl_o.wr_en     = 1'b1;
        ctl_o.vop       = gist_pkg::V_COPY;
        ctl_o.ptr_sel   = gist_pkg::P_INC;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### design/gist_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gist_checker
// Port-level checks on request and result timing.
// ----------------------------------------------------------------------------
module gist_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done_o,
  input wire gist_pkg::rsp_t result_o
);

  // a taken request keeps the block busy in the next cycle
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request taken without going busy");

  // every completion shows its result right after busy drops
  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o) else $error("busy dropped with no result");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while busy");

  // no back to back result strobes
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("back to back result strobes");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.status != 2'd3)) else $error("undefined status code");

endmodule

bind gapped_id_slot_table gist_checker u_gist_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
`default_nettype wire
